/* sv/serial_command_recognizer_macros.svh */
// Assertion helpers included by serial_command_recognizer.sv.
`ifndef SERIAL_COMMAND_RECOGNIZER_MACROS_SVH
`define SERIAL_COMMAND_RECOGNIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/scr_pkg.sv */
`default_nettype none

package scr_pkg;

    localparam int CMD_COUNT = 8;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [4:0] POS_MAX    = 5'd31;

    localparam logic [3:0] CODE_NONE  = 4'd0;
    localparam logic [3:0] CODE_START = 4'd1;
    localparam logic [3:0] CODE_FRAME = 4'd3;
    localparam logic [3:0] CODE_DIR   = 4'd4;
    localparam logic [3:0] CODE_STOP  = 4'd6;

    // Command text, right-justified: char p of command k is byte CMD_LEN[k]-1-p.
    typedef logic [15:0][7:0] cmd_text_t;
    typedef logic [4:0]       cmd_len_t;

    localparam cmd_text_t CMD_TEXT [CMD_COUNT] = '{
        cmd_text_t'("/start"),
        cmd_text_t'("/mask"),
        cmd_text_t'("/frame+"),
        cmd_text_t'("/dir_set+"),
        cmd_text_t'({"/serial", "_out"}),
        cmd_text_t'("/stop"),
        cmd_text_t'({"/single", "_transmit"}),
        cmd_text_t'({"/run", "_predict"})
    };

    localparam cmd_len_t CMD_LEN [CMD_COUNT] = '{
        5'd6, 5'd5, 5'd7, 5'd9, 5'd11, 5'd5, 5'd16, 5'd12
    };

    // Prefix commands and their bit in the extension flags.
    localparam logic [CMD_COUNT-1:0] CMD_IS_PREFIX = 8'b0000_1100;
    localparam logic CMD_SLOT [CMD_COUNT] = '{
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0
    };

    // Expected character at line position pos (pos < CMD_LEN[k]).
    function automatic logic [7:0] cmd_char(input int k, input logic [4:0] pos);
        logic [4:0] idx;
        idx = CMD_LEN[k] - 5'd1 - pos;
        return CMD_TEXT[k][idx[3:0]];
    endfunction

endpackage

`default_nettype wire

/* sv/serial_command_recognizer.sv */
// Serial command recognizer: takes one received byte per cycle and, at each CR or LF,
// returns one word with the matched slash command code (0 for none; commands other than
// "/frame+" and "/dir_set+" match only at CR), the decimal number of a "/frame+" or
// "/dir_set+" line, and the run flag that "/start" sets and "/stop" clears. Other bytes
// give no result. Sustained rate is one byte per cycle; a terminator passes from the
// input register to the result register. The per-line match state updates from the
// input register; a terminator waits there, stalling the input, only while the result
// register holds an untaken word. Ordinary bytes never wait on the output side.
`default_nettype none

`include "serial_command_recognizer_macros.svh"

module serial_command_recognizer #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       command_code,
    output logic [31:0]      number,
    output logic             running
);

    localparam int OUT_W = (NUMBER_WIDTH < 32) ? NUMBER_WIDTH : 32;

    // input stage
    logic                    s1_valid_reg, s1_valid_next;
    logic [7:0]              s1_byte_reg;

    // line state
    logic [scr_pkg::CMD_COUNT-1:0] cand_reg, cand_next;
    logic [4:0]              pos_reg, pos_next;
    logic [1:0]              ext_reg, ext_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    run_reg, run_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [3:0]              code_reg, code_next;
    logic [31:0]             number_reg, number_next;
    logic                    running_reg;

    logic                    is_term;
    logic                    is_digit;
    logic                    out_load_ok;
    logic                    s1_fire;
    logic                    in_fire;
    logic [scr_pkg::CMD_COUNT-1:0] hit;
    logic [3:0]              match_code;

    assign is_term     = (s1_byte_reg == scr_pkg::BYTE_CR) || (s1_byte_reg == scr_pkg::BYTE_LF);
    assign is_digit    = s1_byte_reg inside {[scr_pkg::CHAR_ZERO:scr_pkg::CHAR_NINE]};
    assign out_load_ok = !out_valid_reg || out_ready;
    assign s1_fire     = s1_valid_reg && (!is_term || out_load_ok);
    assign in_ready    = !s1_valid_reg || s1_fire;
    assign in_fire     = in_valid && in_ready;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);

    // per-command hit at a terminator; lowest code wins
    always_comb
    begin
        hit        = '0;
        match_code = scr_pkg::CODE_NONE;
        for (int k = 0; k < scr_pkg::CMD_COUNT; k++)
        begin
            if (scr_pkg::CMD_IS_PREFIX[k])
                hit[k] = cand_reg[k] && ext_reg[scr_pkg::CMD_SLOT[k]];
            else
                hit[k] = cand_reg[k] && (s1_byte_reg == scr_pkg::BYTE_CR)
                         && (pos_reg == scr_pkg::CMD_LEN[k]);
        end
        for (int k = scr_pkg::CMD_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
                match_code = 4'(k + 1);
        end
    end

    always_comb
    begin
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        ext_next       = ext_reg;
        acc_next       = acc_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_next      = code_reg;
        number_next    = number_reg;

        if (s1_fire)
        begin
            if (!is_term)
            begin
                for (int k = 0; k < scr_pkg::CMD_COUNT; k++)
                begin
                    if (cand_reg[k])
                    begin
                        if (pos_reg < scr_pkg::CMD_LEN[k])
                        begin
                            if (s1_byte_reg != scr_pkg::cmd_char(k, pos_reg))
                                cand_next[k] = 1'b0;
                        end
                        else if (scr_pkg::CMD_IS_PREFIX[k])
                        begin
                            if (pos_reg == scr_pkg::CMD_LEN[k])
                                ext_next[scr_pkg::CMD_SLOT[k]] = 1'b1;
                        end
                        else
                        begin
                            cand_next[k] = 1'b0;
                        end
                    end
                end
                if (is_digit)
                    acc_next = (acc_reg << 3) + (acc_reg << 1)
                               + NUMBER_WIDTH'(s1_byte_reg[3:0]);
                if (pos_reg != scr_pkg::POS_MAX)
                    pos_next = pos_reg + 5'd1;
            end
            else
            begin
                out_valid_next = 1'b1;
                code_next      = match_code;
                if (match_code == scr_pkg::CODE_FRAME || match_code == scr_pkg::CODE_DIR)
                    number_next = 32'(acc_reg[OUT_W-1:0]);
                else
                    number_next = '0;
                if (match_code == scr_pkg::CODE_START)
                    run_next = 1'b1;
                else if (match_code == scr_pkg::CODE_STOP)
                    run_next = 1'b0;
                cand_next = '1;
                pos_next  = '0;
                ext_next  = '0;
                acc_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cand_reg      <= '1;
            pos_reg       <= '0;
            ext_reg       <= '0;
            acc_reg       <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            cand_reg      <= cand_next;
            pos_reg       <= pos_next;
            ext_reg       <= ext_next;
            acc_reg       <= acc_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_byte_reg <= rx_byte;
        code_reg    <= code_next;
        number_reg  <= number_next;
        running_reg <= run_next;
    end

    assign out_valid    = out_valid_reg;
    assign command_code = code_reg;
    assign number       = number_reg;
    assign running      = running_reg;

    `SCR_ASSERT_NOW(a_number_only_for_prefix,
        out_valid && command_code != scr_pkg::CODE_FRAME && command_code != scr_pkg::CODE_DIR,
        number == 32'd0, "number set for a command without one")

    `SCR_ASSERT_NOW(a_start_runs,
        out_valid && command_code == scr_pkg::CODE_START, running,
        "start did not set the run flag")

    `SCR_ASSERT_NOW(a_stop_halts,
        out_valid && command_code == scr_pkg::CODE_STOP, !running,
        "stop did not clear the run flag")

    `SCR_ASSERT_NEXT(a_line_cleared,
        s1_fire && is_term, pos_reg == 5'd0 && ext_reg == 2'd0 && (&cand_reg),
        "line state not cleared after terminator")

    `SCR_ASSERT_NOW(a_stall_only_on_full_output,
        !in_ready, s1_valid_reg && is_term && out_valid_reg && !out_ready,
        "input stalled without a blocked terminator")

endmodule

`default_nettype wire
